/* sv/psem_pkg.sv */
// psem_pkg: shared constants for the priority counting semaphore
// no dependencies; used by every other file of the block

package psem_pkg;

  localparam int THREADS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 8;

  localparam int TID_W      = 4;
  localparam int PRIO_REQ_W = 8;
  localparam int INIT_W     = 8;
  localparam int CNT_W      = 12;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [CNT_W-1:0] CNT_MIN = -12'sd128;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 12'sd2047;

  localparam logic OP_WAIT = 1'b0;
  localparam logic OP_POST = 1'b1;

endpackage

/* sv/psem_ifs.sv */
// psem_req_if / psem_rsp_if: valid-ready channels of the semaphore
// depends on psem_pkg for field widths

interface psem_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [psem_pkg::TID_W-1:0]       thread_num;
  logic [psem_pkg::PRIO_REQ_W-1:0]  priority_req;

  modport source (output valid, op, thread_num, priority_req, input ready);
  modport sink   (input valid, op, thread_num, priority_req, output ready);
endinterface

interface psem_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              blocked;
  logic                              released_valid;
  logic [psem_pkg::TID_W-1:0]        released_thread;
  logic signed [psem_pkg::CNT_W-1:0] count_value;
  logic                              saturated;

  modport source (output valid, blocked, released_valid, released_thread, count_value,
                  saturated, input ready);
  modport sink   (input valid, blocked, released_valid, released_thread, count_value,
                  saturated, output ready);
endinterface

/* sv/psem_front.sv */
// psem_front: accepts requests and classifies them into queue entries
// depends on psem_pkg and psem_req_if

module psem_front #(
  parameter int THREADS   = psem_pkg::THREADS_DEF,
  parameter int PRIO_BITS = psem_pkg::PRIO_BITS_DEF,
  localparam int IDX_W    = $clog2(THREADS),
  localparam int ITEM_W   = 2 + IDX_W + PRIO_BITS
) (
  psem_req_if.sink          req,
  input  logic              q_full,
  output logic              q_push,
  output logic [ITEM_W-1:0] q_item
);

  logic [7:0]           tid_ext;
  logic [15:0]          prio_ext;
  logic                 rec;
  logic [IDX_W-1:0]     idx;
  logic [PRIO_BITS-1:0] prio;

  assign tid_ext  = {4'b0, req.thread_num};
  assign prio_ext = {8'b0, req.priority_req};
  // a thread outside the table is never recorded
  assign rec  = (32'(req.thread_num) < THREADS);
  assign idx  = tid_ext[IDX_W-1:0];
  assign prio = prio_ext[PRIO_BITS-1:0];

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;
  assign q_item    = {req.op, rec, idx, prio};

endmodule

/* sv/psem_fifo.sv */
// psem_fifo: short queue between the front and the back
// depends on psem_pkg for the depth

module psem_fifo #(
  parameter int WIDTH = 8,
  localparam int DEPTH = psem_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* sv/psem_back.sv */
// psem_back: count, waiter table, minimum search tree and result register
// depends on psem_pkg and psem_rsp_if

module psem_back #(
  parameter int THREADS   = psem_pkg::THREADS_DEF,
  parameter int PRIO_BITS = psem_pkg::PRIO_BITS_DEF,
  localparam int IDX_W    = $clog2(THREADS),
  localparam int ITEM_W   = 2 + IDX_W + PRIO_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [psem_pkg::INIT_W-1:0] cfg_wr_data,
  input  logic                        q_empty,
  input  logic [ITEM_W-1:0]           q_item,
  output logic                        q_pop,
  psem_rsp_if.source                  rsp
);

  localparam int LEVELS = $clog2(THREADS);
  localparam int NPOW   = 1 << LEVELS;
  localparam int HALF   = NPOW / 2;
  localparam int LVL_W  = $clog2(LEVELS + 1);
  localparam int CW     = psem_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [LVL_W-1:0]      lvl;
  logic signed [CW-1:0]  count;
  logic                  sat_hold;
  logic [PRIO_BITS-1:0]  prio_tab [THREADS];
  logic [PRIO_BITS-1:0]  cand_p [NPOW];
  logic [IDX_W-1:0]      cand_i [NPOW];

  logic                  out_valid;
  logic                  slot_free;

  logic                  it_op;
  logic                  it_rec;
  logic [IDX_W-1:0]      it_idx;
  logic [PRIO_BITS-1:0]  it_prio;

  logic signed [CW-1:0]  cnt_new;
  logic                  sat_new;
  logic                  wait_blk;
  logic                  need_scan;
  logic                  emit;
  logic                  win_found;
  logic [7:0]            win_ext;

  assign {it_op, it_rec, it_idx, it_prio} = q_item;

  assign slot_free = !out_valid || rsp.ready;
  assign q_pop     = (state == S_IDLE) && !q_empty && slot_free;
  assign rsp.valid = out_valid;

  always_comb begin
    sat_new = 1'b0;
    cnt_new = count;
    if (it_op == psem_pkg::OP_WAIT) begin
      if (count <= psem_pkg::CNT_MIN) begin
        sat_new = 1'b1;
      end else begin
        cnt_new = count - CW'(1);
      end
    end else begin
      if (count >= psem_pkg::CNT_MAX) begin
        sat_new = 1'b1;
      end else begin
        cnt_new = count + CW'(1);
      end
    end
  end

  assign wait_blk  = (it_op == psem_pkg::OP_WAIT) && (cnt_new < 0);
  assign need_scan = (it_op == psem_pkg::OP_POST) && (cnt_new <= 0);
  assign win_found = (cand_p[0] != '0);
  assign win_ext   = {{(8 - IDX_W){1'b0}}, cand_i[0]};
  assign emit      = (q_pop && !need_scan) || ((state == S_DONE) && slot_free);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop && need_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lvl == LVL_W'(LEVELS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        prio_tab[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        count <= {{(CW - psem_pkg::INIT_W){1'b0}}, cfg_wr_data};
        for (int i = 0; i < THREADS; i++) begin
          prio_tab[i] <= '0;
        end
      end else if (q_pop) begin
        count <= cnt_new;
        if (wait_blk && it_rec) begin
          prio_tab[it_idx] <= it_prio;
        end
      end else if ((state == S_DONE) && slot_free && win_found) begin
        prio_tab[cand_i[0]] <= '0;
      end
      if (state == S_SCAN) begin
        lvl <= lvl + 1'b1;
      end else begin
        lvl <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // candidate tree: loaded from the table, halved once per cycle while scanning
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sat_hold <= sat_new;
      for (int i = 0; i < NPOW; i++) begin
        cand_i[i] <= IDX_W'(i);
        cand_p[i] <= (i < THREADS) ? prio_tab[i] : '0;
      end
    end else if (state == S_SCAN) begin
      for (int i = 0; i < HALF; i++) begin
        if (cand_p[2*i+1] != '0 &&
            (cand_p[2*i] == '0 || cand_p[2*i+1] < cand_p[2*i])) begin
          cand_p[i] <= cand_p[2*i+1];
          cand_i[i] <= cand_i[2*i+1];
        end else begin
          cand_p[i] <= cand_p[2*i];
          cand_i[i] <= cand_i[2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !need_scan) begin
      rsp.blocked         <= wait_blk;
      rsp.released_valid  <= 1'b0;
      rsp.released_thread <= '0;
      rsp.count_value     <= cnt_new;
      rsp.saturated       <= sat_new;
    end else if ((state == S_DONE) && slot_free) begin
      rsp.blocked         <= 1'b0;
      rsp.released_valid  <= win_found;
      rsp.released_thread <= win_found ? win_ext[psem_pkg::TID_W-1:0] : '0;
      rsp.count_value     <= count;
      rsp.saturated       <= sat_hold;
    end
  end

endmodule

/* sv/priority_counting_semaphore_unit.sv */
// priority counting semaphore: front classifier, queue, back executor
// path: wait, or post with a positive count: request queue, then the result register
// path: other posts: request queue, minimum tree scan in S_SCAN and S_DONE, result register
// throughput: one item per cycle if rsp is ready; a post with count <= 0 holds the back
// reset: count 0, waiter table cleared, queue and result register empty
// depends on psem_pkg, psem_ifs, psem_front, psem_fifo, psem_back

module priority_counting_semaphore_unit #(
  parameter int THREADS   = psem_pkg::THREADS_DEF,
  parameter int PRIO_BITS = psem_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [psem_pkg::INIT_W-1:0] cfg_wr_data,
  psem_req_if.sink                    req,
  psem_rsp_if.source                  rsp
);

  localparam int IDX_W  = $clog2(THREADS);
  localparam int ITEM_W = 2 + IDX_W + PRIO_BITS;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [ITEM_W-1:0] q_in;
  logic [ITEM_W-1:0] q_out;

  psem_front #(
    .THREADS   (THREADS),
    .PRIO_BITS (PRIO_BITS)
  ) u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  psem_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  psem_back #(
    .THREADS   (THREADS),
    .PRIO_BITS (PRIO_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .rsp         (rsp)
  );

endmodule

/* sv/psem_checker.sv */
// psem_checker: port-level checks of the semaphore results
// depends on psem_pkg; bound to priority_counting_semaphore_unit

module psem_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic                              blocked,
  input logic                              released_valid,
  input logic signed [psem_pkg::CNT_W-1:0] count_value,
  input logic                              saturated
);

  // a waiting result is held until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before transfer");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(blocked && released_valid))
    else $error("result both blocked and released");

  a_rel_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && released_valid |-> count_value <= 0)
    else $error("release with positive count");

  a_blk_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && blocked |-> count_value < 0)
    else $error("block with nonnegative count");

  a_blk_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && blocked && saturated |-> count_value == psem_pkg::CNT_MIN)
    else $error("saturated wait not at lower bound");

endmodule

bind priority_counting_semaphore_unit psem_checker u_psem_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .blocked        (rsp.blocked),
  .released_valid (rsp.released_valid),
  .count_value    (rsp.count_value),
  .saturated      (rsp.saturated)
);

/* dv/tb_priority_counting_semaphore_unit.sv */
// tb_priority_counting_semaphore_unit: self-checking testbench for the priority counting semaphore
// depends on psem_pkg, psem_ifs and priority_counting_semaphore_unit
// directed and random wait/post traffic checked against an in-bench semaphore predictor
`timescale 1ns / 100ps

module tb_priority_counting_semaphore_unit;

  localparam int NUM_THREADS = psem_pkg::THREADS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic                            op;
    logic [psem_pkg::TID_W-1:0]      tid;
    logic [psem_pkg::PRIO_REQ_W-1:0] prio;
  } sem_op_t;

  typedef struct {
    logic                              blocked;
    logic                              released_valid;
    logic [psem_pkg::TID_W-1:0]        released_thread;
    logic signed [psem_pkg::CNT_W-1:0] count_value;
    logic                              saturated;
  } sem_result_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [psem_pkg::INIT_W-1:0] cfg_wr_data;

  psem_req_if req_ch ();
  psem_rsp_if rsp_ch ();

  priority_counting_semaphore_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  sem_op_t         pending_ops[$];
  sem_result_t     expected_results[$];
  int              sem_level;
  logic [psem_pkg::PRIO_REQ_W-1:0] waiting_prio[NUM_THREADS];
  int              send_idle_pct;
  int              sink_idle_pct;
  int              error_count;
  int              stall_cycles;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic restart_semaphore(input logic [psem_pkg::INIT_W-1:0] init_value);
    sem_level = int'(init_value);
    for (int i = 0; i < NUM_THREADS; i++) waiting_prio[i] = '0;
  endtask

  task automatic semaphore_step(input logic op, input logic [psem_pkg::TID_W-1:0] tid,
                                input logic [psem_pkg::PRIO_REQ_W-1:0] prio);
    sem_result_t r;
    int best;
    r = '{default: '0};
    if (op == psem_pkg::OP_WAIT) begin
      if (sem_level <= int'(psem_pkg::CNT_MIN)) r.saturated = 1'b1;
      else sem_level--;
      if (sem_level < 0) begin
        r.blocked = 1'b1;
        waiting_prio[tid] = prio;
      end
    end else begin
      if (sem_level >= int'(psem_pkg::CNT_MAX)) r.saturated = 1'b1;
      else sem_level++;
      if (sem_level <= 0) begin
        best = -1;
        for (int i = 0; i < NUM_THREADS; i++) begin
          if (waiting_prio[i] != 0 && (best < 0 || waiting_prio[i] < waiting_prio[best])) best = i;
        end
        if (best >= 0) begin
          waiting_prio[best] = '0;
          r.released_valid = 1'b1;
          r.released_thread = best[psem_pkg::TID_W-1:0];
        end
      end
    end
    r.count_value = sem_level[psem_pkg::CNT_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic check_result();
    sem_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, count_value", int'(rsp_ch.count_value), 0);
      return;
    end
    want = expected_results.pop_front();
    if (rsp_ch.blocked !== want.blocked)
      report_mismatch("blocked", rsp_ch.blocked, want.blocked);
    if (rsp_ch.released_valid !== want.released_valid)
      report_mismatch("released_valid", rsp_ch.released_valid, want.released_valid);
    if (rsp_ch.released_thread !== want.released_thread)
      report_mismatch("released_thread", rsp_ch.released_thread, want.released_thread);
    if (rsp_ch.count_value !== want.count_value)
      report_mismatch("count_value", int'(rsp_ch.count_value), int'(want.count_value));
    if (rsp_ch.saturated !== want.saturated)
      report_mismatch("saturated", rsp_ch.saturated, want.saturated);
  endtask

  // request driver, predicts on every transfer
  always @(posedge clk) begin
    sem_op_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        semaphore_step(req_ch.op, req_ch.thread_num, req_ch.priority_req);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.op <= nxt.op;
          req_ch.thread_num <= nxt.tid;
          req_ch.priority_req <= nxt.prio;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generator
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_op(input logic op, input int tid, input int prio);
    sem_op_t o;
    o.op = op;
    o.tid = tid[psem_pkg::TID_W-1:0];
    o.prio = prio[psem_pkg::PRIO_REQ_W-1:0];
    pending_ops.push_back(o);
  endtask

  task automatic queue_random(input int n, input int wait_pct);
    int r;
    int prio;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      // small priorities make ties common
      if (r < 5) prio = 0;
      else if (r < 50) prio = $urandom_range(1, 4);
      else prio = $urandom_range(1, 255);
      push_op(($urandom_range(0, 99) < wait_pct) ? psem_pkg::OP_WAIT : psem_pkg::OP_POST,
              $urandom_range(0, 15), prio);
    end
  endtask

  task automatic drain_all();
    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_initial(input int init_value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= init_value[psem_pkg::INIT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    restart_semaphore(init_value[psem_pkg::INIT_W-1:0]);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = psem_pkg::OP_WAIT;
    req_ch.thread_num = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready = 1'b0;
    error_count = 0;
    stall_cycles = 0;
    send_idle_pct = 10;
    sink_idle_pct = 10;
    restart_semaphore('0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // waiters, zero priority, repeated wait, posts with nobody waiting
    push_op(psem_pkg::OP_WAIT, 0, 255);
    push_op(psem_pkg::OP_WAIT, 15, 1);
    push_op(psem_pkg::OP_WAIT, 3, 0);
    push_op(psem_pkg::OP_WAIT, 5, 1);
    push_op(psem_pkg::OP_WAIT, 5, 200);
    push_op(psem_pkg::OP_WAIT, 10, 8'h80);
    push_op(psem_pkg::OP_WAIT, 9, 8'h7f);
    push_op(psem_pkg::OP_POST, 7, 1);
    push_op(psem_pkg::OP_POST, 15, 255);
    push_op(psem_pkg::OP_POST, 0, 0);
    push_op(psem_pkg::OP_POST, 8, 8'haa);
    push_op(psem_pkg::OP_POST, 1, 8'h55);
    push_op(psem_pkg::OP_POST, 2, 3);
    push_op(psem_pkg::OP_POST, 4, 9);
    push_op(psem_pkg::OP_POST, 6, 17);
    push_op(psem_pkg::OP_WAIT, 6, 3);
    push_op(psem_pkg::OP_WAIT, 12, 2);
    push_op(psem_pkg::OP_POST, 11, 4);
    drain_all();

    write_initial(255);
    queue_random(60, 50);
    drain_all();

    // long stretch with no idling on either side
    send_idle_pct = 0;
    sink_idle_pct = 0;
    write_initial(0);
    queue_random(260, 55);
    drain_all();
    send_idle_pct = 10;
    sink_idle_pct = 10;

    write_initial($urandom_range(1, 8));
    queue_random(200, 52);
    drain_all();

    write_initial($urandom_range(0, 255));
    queue_random(80, 50);
    drain_all();

    // drive the count down into the lower bound, then release everyone
    write_initial(0);
    queue_random(0, 0);
    for (int k = 0; k < 140; k++)
      push_op(psem_pkg::OP_WAIT, $urandom_range(0, 15), $urandom_range(0, 255));
    for (int k = 0; k < 150; k++)
      push_op(psem_pkg::OP_POST, $urandom_range(0, 15), $urandom_range(0, 255));
    drain_all();

    write_initial(1);
    queue_random(40, 50);
    drain_all();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
